// ===== hdl/tsde_pkg.sv =====
// ----------------------------------------------------------------------------
// tsde_pkg
// Types, codes and constant tables shared by the slot demand estimator.
// ----------------------------------------------------------------------------
package tsde_pkg;

   // field and datapath widths
   localparam int BYTE_W    = 32;   // byte counters and backlog offsets
   localparam int AMT_W     = 16;   // amount field of an input word
   localparam int SLOT_W    = 8;    // slot counts
   localparam int LEN_W     = 14;   // aggregate length table entries
   localparam int FACT_W    = 4;    // slots factor
   localparam int CAP_W     = LEN_W + FACT_W;  // per-slot capacity
   localparam int ACC_W     = CAP_W + SLOT_W;  // capacity times slot count
   localparam int TABLE_LEN = 8;
   localparam int TSEL_W    = 3;    // table entry select
   localparam int CLS_MAX_W = 4;    // class index width at the largest class count

   // input word modes
   localparam logic [1:0] MODE_ENQUEUE   = 2'd0;
   localparam logic [1:0] MODE_DEQUEUE   = 2'd1;
   localparam logic [1:0] MODE_HALF_FULL = 2'd2;
   localparam logic [1:0] MODE_TICK      = 2'd3;

   // bandwidth modes
   localparam logic [1:0] BW_20MHZ    = 2'd0;
   localparam logic [1:0] BW_10MHZ    = 2'd1;
   localparam logic [1:0] BW_5MHZ     = 2'd2;
   localparam logic [1:0] BW_RESERVED = 2'd3;

   // register indexes
   localparam int CSR_IDX_W = 3;
   localparam logic [CSR_IDX_W-1:0] CSR_BANDWIDTH_MODE      = 3'd0;
   localparam logic [CSR_IDX_W-1:0] CSR_HEADER_OVERHEAD     = 3'd1;
   localparam logic [CSR_IDX_W-1:0] CSR_SLOTS_FACTOR        = 3'd2;
   localparam logic [CSR_IDX_W-1:0] CSR_MAX_SLOTS           = 3'd3;
   localparam logic [CSR_IDX_W-1:0] CSR_RESERVED_SLOT_VALUE = 3'd4;
   localparam int CSR_DATA_W = 8;

   // register reset values
   localparam logic [1:0]        RST_BANDWIDTH_MODE      = BW_20MHZ;
   localparam logic [7:0]        RST_HEADER_OVERHEAD     = 8'd36;
   localparam logic [FACT_W-1:0] RST_SLOTS_FACTOR        = 4'd4;
   localparam logic [SLOT_W-1:0] RST_MAX_SLOTS           = 8'd16;
   localparam logic [SLOT_W-1:0] RST_RESERVED_SLOT_VALUE = 8'd255;

   // aggregate lengths in bytes, one row per bandwidth mode
   localparam logic [LEN_W-1:0] LEN_20MHZ [TABLE_LEN] = '{
      14'd1344, 14'd1792, 14'd2688, 14'd3584, 14'd5472, 14'd7296, 14'd8160, 14'd10880};
   localparam logic [LEN_W-1:0] LEN_10MHZ [TABLE_LEN] = '{
      14'd672, 14'd896, 14'd1344, 14'd1792, 14'd2688, 14'd3584, 14'd4032, 14'd5376};
   localparam logic [LEN_W-1:0] LEN_5MHZ [TABLE_LEN] = '{
      14'd288, 14'd384, 14'd576, 14'd768, 14'd1248, 14'd1664, 14'd1920, 14'd2560};

   typedef struct packed {
      logic [1:0]        bandwidth_mode;
      logic [7:0]        header_overhead;
      logic [FACT_W-1:0] slots_factor;
      logic [SLOT_W-1:0] max_slots;
      logic [SLOT_W-1:0] reserved_slot_value;
   } cfg_type;

   // controller to datapath
   typedef struct packed {
      logic accum;    // fold an accepted counting word into the counters
      logic start;    // tick accepted: reset class pointer and running total
      logic load;     // fetch the current class and its payload size
      logic cap;      // form capacity and demand
      logic step;     // grant one more slot
      logic next;     // write back offset, clear counters, advance class
      logic finish;   // load the result register
   } cmd_type;

   // datapath to controller
   typedef struct packed {
      logic more;        // budget left and capacity still short of demand
      logic last_class;
   } status_type;

   // aggregate length for a bandwidth mode and table entry
   function automatic logic [LEN_W-1:0] agg_len(input logic [1:0] bw,
                                                input logic [TSEL_W-1:0] sel);
      logic [LEN_W-1:0] len;
      case (bw)
         BW_10MHZ: len = LEN_10MHZ[sel];
         BW_5MHZ:  len = LEN_5MHZ[sel];
         default:  len = LEN_20MHZ[sel];   // 20 MHz and the unused code
      endcase
      return len;
   endfunction

endpackage

// ===== hdl/tdma_slot_demand_estimator_top.sv =====
// ----------------------------------------------------------------------------
// tdma_slot_demand_estimator_top
// Slot demand estimator for a TDMA link: counts queued bytes per rate class
// and turns them into a slot request on each period tick.
// ----------------------------------------------------------------------------
// Enqueue, dequeue and half-full words are taken one per cycle, back to back,
// while the block is idle, and produce no result. A tick word walks the
// classes one at a time through a single shared slot-grant counter: each
// class passes the load, capacity, fill and next states in turn, and the
// fill state grants slots until capacity covers demand or the budget runs
// out. Input is stalled from the tick until the slot count is loaded into
// the output register; counting words are taken again while it waits on
// rsp_stall. Registers are written through csr_wr_en / csr_index /
// csr_wr_data while the block is idle: a rule for the user that the block itself does not enforce; it reads them live.
// ----------------------------------------------------------------------------
module tdma_slot_demand_estimator_top #(
   parameter int NUM_CLASSES = 8
) (
   input  logic                              clock,
   input  logic                              reset,
   // configuration
   input  logic                              csr_wr_en,
   input  logic [tsde_pkg::CSR_IDX_W-1:0]    csr_index,
   input  logic [tsde_pkg::CSR_DATA_W-1:0]   csr_wr_data,
   // input words
   input  logic                              req_valid,
   output logic                              req_stall,
   input  logic [1:0]                        req_mode,
   input  logic [2:0]                        req_class_index,
   input  logic [tsde_pkg::AMT_W-1:0]        req_amount,
   // result words
   output logic                              rsp_valid,
   input  logic                              rsp_stall,
   output logic [tsde_pkg::SLOT_W-1:0]       rsp_slot_count
);
   import tsde_pkg::*;

   cfg_type    cfg_ff, cfg_in;
   cmd_type    cmd;
   status_type status;

   // register write decode
   always_comb begin
      cfg_in = cfg_ff;
      if (csr_wr_en) begin
         unique case (csr_index)
            CSR_BANDWIDTH_MODE:      cfg_in.bandwidth_mode      = csr_wr_data[1:0];
            CSR_HEADER_OVERHEAD:     cfg_in.header_overhead     = csr_wr_data;
            CSR_SLOTS_FACTOR:        cfg_in.slots_factor        = csr_wr_data[FACT_W-1:0];
            CSR_MAX_SLOTS:           cfg_in.max_slots           = csr_wr_data;
            CSR_RESERVED_SLOT_VALUE: cfg_in.reserved_slot_value = csr_wr_data;
            default:                 cfg_in = cfg_ff;
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         cfg_ff.bandwidth_mode      <= RST_BANDWIDTH_MODE;
         cfg_ff.header_overhead     <= RST_HEADER_OVERHEAD;
         cfg_ff.slots_factor        <= RST_SLOTS_FACTOR;
         cfg_ff.max_slots           <= RST_MAX_SLOTS;
         cfg_ff.reserved_slot_value <= RST_RESERVED_SLOT_VALUE;
      end else begin
         cfg_ff <= cfg_in;
      end
   end

   tsde_ctrl u_ctrl (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_valid),
      .req_mode  (req_mode),
      .req_stall (req_stall),
      .rsp_valid (rsp_valid),
      .rsp_stall (rsp_stall),
      .cmd       (cmd),
      .status    (status)
   );

   tsde_dp #(
      .NUM_CLASSES (NUM_CLASSES)
   ) u_dp (
      .clock           (clock),
      .reset           (reset),
      .cfg             (cfg_ff),
      .cmd             (cmd),
      .status          (status),
      .req_mode        (req_mode),
      .req_class_index (req_class_index),
      .req_amount      (req_amount),
      .rsp_slot_count  (rsp_slot_count)
   );

endmodule

// ===== hdl/tsde_ctrl.sv =====
// ----------------------------------------------------------------------------
// tsde_ctrl
// Sequencer: takes counting words in idle, walks the classes on a tick and
// hands the total to the result register.
// ----------------------------------------------------------------------------
module tsde_ctrl (
   input  logic                clock,
   input  logic                reset,
   input  logic                req_valid,
   input  logic [1:0]          req_mode,
   output logic                req_stall,
   output logic                rsp_valid,
   input  logic                rsp_stall,
   output tsde_pkg::cmd_type    cmd,
   input  tsde_pkg::status_type status
);
   import tsde_pkg::*;

   typedef enum logic [5:0] {
      ST_IDLE   = 6'b000001,
      ST_LOAD   = 6'b000010,
      ST_CAP    = 6'b000100,
      ST_FILL   = 6'b001000,
      ST_NEXT   = 6'b010000,
      ST_FINISH = 6'b100000
   } state_type;

   state_type state_ff, state_in;
   logic      rsp_valid_ff, rsp_valid_in;
   logic      req_accept;
   logic      out_free;

   assign req_stall  = (state_ff != ST_IDLE);
   assign req_accept = req_valid && !req_stall;
   assign out_free   = !rsp_valid_ff || !rsp_stall;
   assign rsp_valid  = rsp_valid_ff;

   // next state and commands
   always_comb begin
      state_in   = state_ff;
      cmd        = '0;
      unique case (state_ff)
         ST_IDLE: begin
            if (req_accept) begin
               if (req_mode == MODE_TICK) begin
                  cmd.start = 1'b1;
                  state_in  = ST_LOAD;
               end else begin
                  cmd.accum = 1'b1;
               end
            end
         end
         ST_LOAD: begin
            cmd.load = 1'b1;
            state_in = ST_CAP;
         end
         ST_CAP: begin
            cmd.cap  = 1'b1;
            state_in = ST_FILL;
         end
         ST_FILL: begin
            if (status.more) begin
               cmd.step = 1'b1;
            end else begin
               state_in = ST_NEXT;
            end
         end
         ST_NEXT: begin
            cmd.next = 1'b1;
            state_in = status.last_class ? ST_FINISH : ST_LOAD;
         end
         ST_FINISH: begin
            if (out_free) begin
               cmd.finish = 1'b1;
               state_in   = ST_IDLE;
            end
         end
         default: state_in = ST_IDLE;
      endcase
   end

   // result valid flag
   always_comb begin
      rsp_valid_in = rsp_valid_ff;
      if (cmd.finish) begin
         rsp_valid_in = 1'b1;
      end else if (rsp_valid_ff && !rsp_stall) begin
         rsp_valid_in = 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_IDLE;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

endmodule

// ===== hdl/tsde_dp.sv =====
// ----------------------------------------------------------------------------
// tsde_dp
// Datapath: per-class byte counters, backlog offsets, extra slot count, the
// slot grant loop and the result register.
// ----------------------------------------------------------------------------
module tsde_dp #(
   parameter int NUM_CLASSES = 8
) (
   input  logic                          clock,
   input  logic                          reset,
   input  tsde_pkg::cfg_type              cfg,
   input  tsde_pkg::cmd_type              cmd,
   output tsde_pkg::status_type           status,
   input  logic [1:0]                    req_mode,
   input  logic [2:0]                    req_class_index,
   input  logic [tsde_pkg::AMT_W-1:0]     req_amount,
   output logic [tsde_pkg::SLOT_W-1:0]    rsp_slot_count
);
   import tsde_pkg::*;

   localparam int CLS_W = (NUM_CLASSES > 1) ? $clog2(NUM_CLASSES) : 1;

   // per-class counters
   logic [BYTE_W-1:0] enq_ff [NUM_CLASSES];
   logic [BYTE_W-1:0] deq_ff [NUM_CLASSES];
   logic [BYTE_W-1:0] off_ff [NUM_CLASSES];
   logic [SLOT_W-1:0] pend_ff, pend_in;

   // tick working registers
   logic [CLS_W-1:0]  idx_ff;
   logic [BYTE_W-1:0] enq_cur_ff, deq_cur_ff, off_cur_ff, demand_ff;
   logic [LEN_W-1:0]  pay_ff;
   logic [CAP_W-1:0]  cap_ff;
   logic [ACC_W-1:0]  acc_ff;
   logic [SLOT_W-1:0] n_ff;
   logic [SLOT_W-1:0] total_ff;
   logic [SLOT_W-1:0] result_ff;

   logic              in_range;
   logic [CLS_W-1:0]  word_idx;
   logic [CLS_MAX_W-1:0] idx_wide;
   logic [TSEL_W-1:0] tsel;
   logic [LEN_W-1:0]  len;
   logic [LEN_W-1:0]  pay;
   logic [AMT_W:0]    pend_sum;
   logic [BYTE_W-1:0] off_new;
   logic              fits_cap;
   logic [SLOT_W:0]   final_sum;
   logic [SLOT_W-1:0] clamped;

   // counting word decode
   assign in_range = int'(req_class_index) < NUM_CLASSES;
   assign word_idx = CLS_W'(req_class_index);

   // half-full extra slots saturate
   assign pend_sum = {1'b0, req_amount} + (AMT_W + 1)'(pend_ff);
   always_comb begin
      pend_in = pend_ff;
      if (cmd.finish) begin
         pend_in = '0;
      end else if (cmd.accum && req_mode == MODE_HALF_FULL) begin
         pend_in = (pend_sum > (AMT_W + 1)'(8'hFF)) ? 8'hFF : pend_sum[SLOT_W-1:0];
      end
   end

   // payload bytes per aggregate; classes past the table use its last entry
   assign idx_wide = CLS_MAX_W'(idx_ff);
   assign tsel     = (idx_wide > CLS_MAX_W'(TABLE_LEN - 1)) ?
                     TSEL_W'(TABLE_LEN - 1) : idx_wide[TSEL_W-1:0];
   assign len      = agg_len((cfg.bandwidth_mode == BW_RESERVED) ? BW_20MHZ
                                                                 : cfg.bandwidth_mode, tsel);
   assign pay      = (len > LEN_W'(cfg.header_overhead)) ?
                     len - LEN_W'(cfg.header_overhead) : '0;

   // offset update: demand minus dequeued, dropped on underrun or when both fit
   assign off_new  = demand_ff - deq_cur_ff;
   assign fits_cap = (deq_cur_ff <= BYTE_W'(cap_ff)) && (enq_cur_ff <= BYTE_W'(cap_ff));

   // grant loop status
   assign status.more       = (total_ff < cfg.max_slots) && (BYTE_W'(acc_ff) < demand_ff);
   assign status.last_class = (idx_ff == CLS_W'(NUM_CLASSES - 1));

   // final total: add extra slots, clamp to budget, hide the reserved value
   assign final_sum = (SLOT_W + 1)'(total_ff) + (SLOT_W + 1)'(pend_ff);
   assign clamped   = (final_sum > (SLOT_W + 1)'(cfg.max_slots)) ?
                      cfg.max_slots : final_sum[SLOT_W-1:0];

   // per-class counter arrays
   always_ff @(posedge clock) begin
      if (reset) begin
         for (int i = 0; i < NUM_CLASSES; i++) begin
            enq_ff[i] <= '0;
            deq_ff[i] <= '0;
            off_ff[i] <= '0;
         end
         pend_ff <= '0;
      end else begin
         pend_ff <= pend_in;
         if (cmd.accum && in_range && req_mode == MODE_ENQUEUE) begin
            enq_ff[word_idx] <= enq_ff[word_idx] + BYTE_W'(req_amount);
         end
         if (cmd.accum && in_range && req_mode == MODE_DEQUEUE) begin
            deq_ff[word_idx] <= deq_ff[word_idx] + BYTE_W'(req_amount);
         end
         if (cmd.next) begin
            enq_ff[idx_ff] <= '0;
            deq_ff[idx_ff] <= '0;
            off_ff[idx_ff] <= ((deq_cur_ff <= demand_ff) && !fits_cap) ? off_new : '0;
         end
      end
   end

   // class walk and slot grant
   always_ff @(posedge clock) begin
      if (reset) begin
         idx_ff   <= '0;
         total_ff <= '0;
         n_ff     <= '0;
      end else begin
         if (cmd.start) begin
            idx_ff   <= '0;
            total_ff <= '0;
         end
         if (cmd.load) begin
            n_ff <= '0;
         end
         if (cmd.step) begin
            n_ff     <= n_ff + SLOT_W'(1);
            total_ff <= total_ff + SLOT_W'(1);
         end
         if (cmd.next) begin
            idx_ff <= idx_ff + CLS_W'(1);
            if (n_ff == cfg.reserved_slot_value) begin
               total_ff <= total_ff - n_ff;
            end
         end
      end
   end

   // per-class operands
   always_ff @(posedge clock) begin
      if (cmd.load) begin
         enq_cur_ff <= enq_ff[idx_ff];
         deq_cur_ff <= deq_ff[idx_ff];
         off_cur_ff <= off_ff[idx_ff];
         pay_ff     <= pay;
         acc_ff     <= '0;
      end
      if (cmd.cap) begin
         cap_ff    <= CAP_W'(pay_ff) * CAP_W'(cfg.slots_factor);
         demand_ff <= enq_cur_ff + off_cur_ff;
      end
      if (cmd.step) begin
         acc_ff <= acc_ff + ACC_W'(cap_ff);
      end
      if (cmd.finish) begin
         result_ff <= (clamped == cfg.reserved_slot_value) ? '0 : clamped;
      end
   end

   assign rsp_slot_count = result_ff;

endmodule

// ===== bench/tb_top.sv =====
// ----------------------------------------------------------------------------
// tb_top
// Self-checking bench for the TDMA slot demand estimator. Counting words and
// period ticks are driven through the req_ channel with random gaps. Each
// accepted word is folded into a local estimator, which queues the slot count
// expected for each tick. rsp_ words are checked against that queue in order.
// ----------------------------------------------------------------------------
module tb_top;
   timeunit 1ns;
   timeprecision 1ps;
   import tsde_pkg::*;

   localparam int NCLS         = 8;
   localparam int IDLE_PCT     = 18;
   localparam int LONG_HOLD    = 400;    // receiver back-pressure stretch
   localparam int STALL_LIMIT  = 4000;   // cycles with no transfer at all
   localparam int DRAIN_CYCLES = 10;     // settle time before a register write
   localparam int TAIL_CYCLES  = 400;    // tail wait before the final report

   typedef struct {
      logic [1:0]       mode;
      logic [2:0]       cls;
      logic [AMT_W-1:0] amount;
      bit               after_drain;   // hold this word until all counts are in
   } word_type;

   logic                  clock;
   logic                  reset       = 1'b1;
   logic                  csr_wr_en   = 1'b0;
   logic [CSR_IDX_W-1:0]  csr_index   = '0;
   logic [CSR_DATA_W-1:0] csr_wr_data = '0;
   logic                  req_valid   = 1'b0;
   logic                  req_stall;
   logic [1:0]            req_mode        = MODE_ENQUEUE;
   logic [2:0]            req_class_index = '0;
   logic [AMT_W-1:0]      req_amount      = '0;
   logic                  rsp_valid;
   logic                  rsp_stall   = 1'b0;
   logic [SLOT_W-1:0]     rsp_slot_count;

   word_type          pending_words[$];
   logic [SLOT_W-1:0] slot_count_expected[$];

   // local copy of the registers
   logic [1:0]        cfg_bw;
   logic [7:0]        cfg_ovh;
   logic [FACT_W-1:0] cfg_fac;
   logic [SLOT_W-1:0] cfg_max;
   logic [SLOT_W-1:0] cfg_rsv;

   // local copy of the per-period counters and carried offsets
   logic [BYTE_W-1:0] enq_sum  [NCLS];
   logic [BYTE_W-1:0] deq_sum  [NCLS];
   logic [BYTE_W-1:0] carry_off[NCLS];
   int unsigned       extra_slots;

   int  errors       = 0;
   int  quiet_cycles = 0;
   bit  req_taken    = 1'b0;
   bit  calm         = 1'b0;   // no random idling on either side
   bit  hold_go      = 1'b0;
   bit  hold_done    = 1'b0;
   int  hold_left    = 0;

   tdma_slot_demand_estimator_top #(.NUM_CLASSES(NCLS)) u_top (
      .clock          (clock),
      .reset          (reset),
      .csr_wr_en      (csr_wr_en),
      .csr_index      (csr_index),
      .csr_wr_data    (csr_wr_data),
      .req_valid      (req_valid),
      .req_stall      (req_stall),
      .req_mode       (req_mode),
      .req_class_index(req_class_index),
      .req_amount     (req_amount),
      .rsp_valid      (rsp_valid),
      .rsp_stall      (rsp_stall),
      .rsp_slot_count (rsp_slot_count)
   );

   initial begin
      clock = 1'b0;
      forever #5 clock = ~clock;
   end

   task automatic note_error(input string msg);
      errors++;
      if (errors <= 10) $display("%s", msg);
   endtask

   // slot count for a period tick; updates offsets and clears the counters
   task automatic tick_slots(output logic [SLOT_W-1:0] slots);
      longint unsigned   pay;
      longint unsigned   cap;
      logic [LEN_W-1:0]  len;
      logic [BYTE_W-1:0] demand;
      int unsigned       total;
      int unsigned       n;
      int                sel;
      total = 0;
      for (int i = 0; i < NCLS; i++) begin
         sel = (i < TABLE_LEN) ? i : TABLE_LEN - 1;
         case (cfg_bw)
            BW_10MHZ: len = LEN_10MHZ[sel];
            BW_5MHZ:  len = LEN_5MHZ[sel];
            default:  len = LEN_20MHZ[sel];
         endcase
         pay = (len > cfg_ovh) ? len - cfg_ovh : 0;
         cap = pay * cfg_fac;
         demand = enq_sum[i] + carry_off[i];
         // carried backlog: grows by the net, dropped once the queue drained
         if (deq_sum[i] <= demand) carry_off[i] = carry_off[i] + enq_sum[i] - deq_sum[i];
         else carry_off[i] = '0;
         if (deq_sum[i] <= cap && enq_sum[i] <= cap) carry_off[i] = '0;
         // fewest slots covering demand, within what is left of the budget
         n = 0;
         while (total < cfg_max && cap * n < demand) begin
            n++;
            total++;
         end
         if (n == cfg_rsv) total -= n;
         enq_sum[i] = '0;
         deq_sum[i] = '0;
      end
      total += extra_slots;
      extra_slots = 0;
      if (total > cfg_max) total = cfg_max;
      if (total == cfg_rsv) total = 0;
      slots = total[SLOT_W-1:0];
   endtask

   task automatic absorb_word(input logic [1:0] mode, input logic [2:0] cls,
                              input logic [AMT_W-1:0] amount);
      logic [SLOT_W-1:0] slots;
      case (mode)
         MODE_ENQUEUE:   if (cls < NCLS) enq_sum[cls] += amount;
         MODE_DEQUEUE:   if (cls < NCLS) deq_sum[cls] += amount;
         MODE_HALF_FULL: begin
            extra_slots += amount;
            if (extra_slots > 255) extra_slots = 255;
         end
         default: begin
            tick_slots(slots);
            slot_count_expected.push_back(slots);
         end
      endcase
   endtask

   // accept side: check results, then fold in the accepted word
   always @(posedge clock) begin : monitor
      logic [SLOT_W-1:0] want;
      if (reset) begin
         req_taken <= 1'b0;
      end else begin
         req_taken <= req_valid && !req_stall;
         if (rsp_valid && !rsp_stall) begin
            if (slot_count_expected.size() == 0) begin
               note_error($sformatf("unexpected slot_count word: %0d", rsp_slot_count));
            end else begin
               want = slot_count_expected.pop_front();
               if (rsp_slot_count !== want)
                  note_error($sformatf("slot_count: expected %0d, got %0d",
                                       want, rsp_slot_count));
            end
         end
         if (req_valid && !req_stall) absorb_word(req_mode, req_class_index, req_amount);
      end
   end

   // sender: present the next word once the previous one has gone
   always @(negedge clock) begin : driver
      word_type w;
      if (reset) begin
         req_valid <= 1'b0;
      end else if (!req_valid || req_taken) begin
         if (pending_words.size() != 0
             && !(pending_words[0].after_drain && slot_count_expected.size() != 0)
             && (calm || $urandom_range(0, 99) >= IDLE_PCT)) begin
            w = pending_words.pop_front();
            req_valid       <= 1'b1;
            req_mode        <= w.mode;
            req_class_index <= w.cls;
            req_amount      <= w.amount;
         end else begin
            req_valid <= 1'b0;
         end
      end
   end

   // receiver: random stalls plus one long hold-off
   always @(negedge clock) begin : receiver
      if (reset) begin
         rsp_stall <= 1'b0;
      end else if (hold_left > 0) begin
         rsp_stall <= 1'b1;
         hold_left--;
      end else if (hold_go && !hold_done) begin
         hold_done = 1'b1;
         hold_left = LONG_HOLD - 1;
         rsp_stall <= 1'b1;
      end else begin
         rsp_stall <= !calm && ($urandom_range(0, 99) < IDLE_PCT);
      end
   end

   // watchdog on cycles with no transfer on either channel
   always @(posedge clock) begin
      if (reset || (req_valid && !req_stall) || (rsp_valid && !rsp_stall)) begin
         quiet_cycles <= 0;
      end else if (quiet_cycles >= STALL_LIMIT) begin
         $display("Mismatches found");
         $finish;
      end else begin
         quiet_cycles <= quiet_cycles + 1;
      end
   end

   task automatic add_word(input logic [1:0] mode, input int unsigned cls,
                           input int unsigned amount);
      word_type w;
      w.mode        = mode;
      w.cls         = cls[2:0];
      w.amount      = amount[AMT_W-1:0];
      w.after_drain = 1'b0;
      pending_words.push_back(w);
   endtask

   task automatic write_reg(input logic [CSR_IDX_W-1:0] idx, input logic [7:0] val);
      @(negedge clock);
      csr_wr_en   <= 1'b1;
      csr_index   <= idx;
      csr_wr_data <= val;
      @(negedge clock);
      csr_wr_en <= 1'b0;
      case (idx)
         CSR_BANDWIDTH_MODE:      cfg_bw  = val[1:0];
         CSR_HEADER_OVERHEAD:     cfg_ovh = val;
         CSR_SLOTS_FACTOR:        cfg_fac = val[FACT_W-1:0];
         CSR_MAX_SLOTS:           cfg_max = val;
         CSR_RESERVED_SLOT_VALUE: cfg_rsv = val;
         default: ;
      endcase
   endtask

   task automatic set_config(input logic [1:0] bw, input logic [7:0] ovh,
                             input logic [FACT_W-1:0] fac, input logic [7:0] mx,
                             input logic [7:0] rsv);
      write_reg(CSR_BANDWIDTH_MODE, {6'd0, bw});
      write_reg(CSR_HEADER_OVERHEAD, ovh);
      write_reg(CSR_SLOTS_FACTOR, {4'd0, fac});
      write_reg(CSR_MAX_SLOTS, mx);
      write_reg(CSR_RESERVED_SLOT_VALUE, rsv);
   endtask

   // everything sent, every count back, then a DRAIN_CYCLES settling wait
   task automatic wait_idle();
      while (pending_words.size() != 0 || req_valid || slot_count_expected.size() != 0)
         @(posedge clock);
      repeat (DRAIN_CYCLES) @(posedge clock);
   endtask

   function automatic int unsigned pick_amount(input logic [1:0] mode);
      int unsigned r;
      r = $urandom_range(0, 99);
      if (mode == MODE_HALF_FULL) return (r < 75) ? $urandom_range(0, 8) : $urandom;
      if (r < 30) return $urandom_range(0, 65535);
      if (r < 70) return $urandom_range(0, 2000);
      return $urandom_range(2000, 15000);
   endfunction

   // mostly whole periods (counting words closed by a tick), some loose words
   task automatic gen_random(input int count);
      int          made;
      int          len;
      int unsigned r;
      logic [1:0]  mode;
      made = 0;
      while (made < count) begin
         if ($urandom_range(0, 99) < 85) begin
            len = $urandom_range(1, 10);
            for (int k = 0; k < len; k++) begin
               r = $urandom_range(0, 99);
               mode = (r < 50) ? MODE_ENQUEUE : (r < 85) ? MODE_DEQUEUE : MODE_HALF_FULL;
               add_word(mode, $urandom_range(0, 7), pick_amount(mode));
            end
            add_word(MODE_TICK, $urandom_range(0, 7), $urandom);
            made += len + 1;
         end else begin
            mode = 2'($urandom_range(0, 3));
            add_word(mode, $urandom_range(0, 7), pick_amount(mode));
            made++;
         end
      end
   endtask

   task automatic random_config();
      logic [1:0]        bw;
      logic [7:0]        ovh;
      logic [FACT_W-1:0] fac;
      logic [7:0]        mx;
      logic [7:0]        rsv;
      bw  = 2'($urandom_range(0, 3));
      ovh = 8'($urandom_range(0, 255));
      fac = FACT_W'($urandom_range(1, 15));
      mx  = ($urandom_range(0, 3) == 0) ? 8'($urandom_range(1, 255))
                                        : 8'($urandom_range(1, 40));
      rsv = ($urandom_range(0, 1) == 0) ? 8'($urandom_range(0, 12))
                                        : 8'($urandom_range(0, 255));
      set_config(bw, ovh, fac, mx, rsv);
   endtask

   initial begin
      cfg_bw  = RST_BANDWIDTH_MODE;
      cfg_ovh = RST_HEADER_OVERHEAD;
      cfg_fac = RST_SLOTS_FACTOR;
      cfg_max = RST_MAX_SLOTS;
      cfg_rsv = RST_RESERVED_SLOT_VALUE;
      for (int i = 0; i < NCLS; i++) begin
         enq_sum[i]   = '0;
         deq_sum[i]   = '0;
         carry_off[i] = '0;
      end
      extra_slots = 0;
      repeat (6) @(posedge clock);
      @(negedge clock);
      reset <= 1'b0;

      // reset settings: empty tick, field extremes, half-full saturation,
      // dequeue beyond demand, offset cleared inside capacity and carried past it
      add_word(MODE_TICK, 0, 0);
      add_word(MODE_ENQUEUE, 0, 0);
      add_word(MODE_ENQUEUE, 7, 65535);
      add_word(MODE_DEQUEUE, 3, 65535);
      add_word(MODE_HALF_FULL, 5, 65535);
      add_word(MODE_HALF_FULL, 2, 1);
      add_word(MODE_TICK, 7, 65535);
      add_word(MODE_ENQUEUE, 1, 5000);
      add_word(MODE_DEQUEUE, 1, 100);
      add_word(MODE_ENQUEUE, 2, 40000);
      add_word(MODE_DEQUEUE, 2, 1000);
      add_word(MODE_HALF_FULL, 4, 0);
      add_word(MODE_TICK, 1, 0);
      add_word(MODE_TICK, 6, 0);
      wait_idle();

      // smallest budget, zero overhead, reserved value zero
      set_config(BW_10MHZ, 8'd0, 4'd1, 8'd1, 8'd0);
      add_word(MODE_ENQUEUE, 6, 1);
      add_word(MODE_TICK, 0, 0);
      add_word(MODE_HALF_FULL, 0, 3);
      add_word(MODE_TICK, 0, 0);
      wait_idle();

      // largest budget and factor, clamp of the sum onto the reserved value
      set_config(BW_5MHZ, 8'd255, 4'd15, 8'd255, 8'd255);
      add_word(MODE_ENQUEUE, 0, 65535);
      add_word(MODE_ENQUEUE, 4, 65535);
      add_word(MODE_ENQUEUE, 7, 65535);
      add_word(MODE_HALF_FULL, 0, 200);
      add_word(MODE_TICK, 0, 0);
      add_word(MODE_TICK, 0, 0);
      wait_idle();

      // unused bandwidth code, one class landing on the reserved slot count
      set_config(BW_RESERVED, 8'd100, 4'd7, 8'd40, 8'd3);
      add_word(MODE_ENQUEUE, 0, 20000);
      add_word(MODE_TICK, 0, 0);
      wait_idle();

      // random phases, each under its own settings
      for (int ph = 0; ph < 5; ph++) begin
         random_config();
         gen_random(100);
         if (ph == 1) pending_words[50].after_drain = 1'b1;
         if (ph == 2) calm = 1'b1;
         if (ph == 0) begin
            @(posedge clock);
            hold_go = 1'b1;
         end
         wait_idle();
         calm = 1'b0;
      end

      repeat (TAIL_CYCLES) @(posedge clock);
      if (errors == 0) begin
         $display("No mismatches found");
      end else begin
         $display("Mismatches found");
      end
      $finish;
   end

endmodule
